/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define LMSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmsc assertion failed");

// Next-cycle implication, disabled while reset is active.
`define LMSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmsc assertion failed");

`endif

/* design/lmsc_pkg.sv */
// Types and constants of the level meter and silence chunker.
package lmsc_pkg;

  localparam int LevelBits = 15;
  localparam int FracBits  = 16;
  localparam int CfgIdxBits = 3;

  localparam logic [LevelBits-1:0] LevelMax = 15'h7fff;

  localparam logic [FracBits-1:0]  AttackReset    = 16'd39322;
  localparam logic [FracBits-1:0]  ReleaseReset   = 16'd9830;
  localparam logic [LevelBits-1:0] ThresholdReset = 15'd655;
  localparam logic [31:0]          PauseReset     = 32'd16800;
  localparam logic [31:0]          ChunkMinReset  = 32'd72000;
  localparam logic [31:0]          ChunkMaxReset  = 32'd384000;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2
  } opcode_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_ATTACK    = 3'd0,
    CFG_RELEASE   = 3'd1,
    CFG_LIVE_MODE = 3'd2,
    CFG_THRESHOLD = 3'd3,
    CFG_PAUSE     = 3'd4,
    CFG_CHUNK_MIN = 3'd5,
    CFG_CHUNK_MAX = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [FracBits-1:0]  attack_fraction;
    logic [FracBits-1:0]  release_fraction;
    logic                 live_mode;
    logic [LevelBits-1:0] silence_threshold;
  } meter_cfg_t;

  // One input item after the front stage: magnitude already in Q0.15.
  typedef struct packed {
    opcode_e              opcode;
    logic [LevelBits-1:0] mag;
    logic                 buffer_end;
  } item_t;

endpackage

/* design/lmsc_in_if.sv */
// Input stream channel: opcode, sample and buffer end.
interface lmsc_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          buffer_end;

  modport source (output valid, output opcode, output sample, output buffer_end, input ready);
  modport sink   (input valid, input opcode, input sample, input buffer_end, output ready);
endinterface

/* design/lmsc_out_if.sv */
// Result stream channel: level, cut flags and chunk length.
interface lmsc_out_if #(
  parameter int COUNT_BITS = 24
) ();
  logic                  valid;
  logic                  ready;
  logic [14:0]           level;
  logic                  cut;
  logic                  final_chunk;
  logic [COUNT_BITS-1:0] chunk_length;

  modport source (output valid, output level, output cut, output final_chunk,
                  output chunk_length, input ready);
  modport sink   (input valid, input level, input cut, input final_chunk,
                  input chunk_length, output ready);
endinterface

/* design/lmsc_cfg_regs.sv */
// Configuration register file of the level meter and silence chunker.
module lmsc_cfg_regs #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lmsc_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [COUNT_BITS-1:0]                cfg_wdata_i,
  output lmsc_pkg::meter_cfg_t                 meter_cfg_o,
  output logic [COUNT_BITS-1:0]                pause_samples_o,
  output logic [COUNT_BITS-1:0]                chunk_min_o,
  output logic [COUNT_BITS-1:0]                chunk_max_o
);
  import lmsc_pkg::*;

  meter_cfg_t            meter_q;
  logic [COUNT_BITS-1:0] pause_q;
  logic [COUNT_BITS-1:0] min_q;
  logic [COUNT_BITS-1:0] max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meter_q.attack_fraction   <= AttackReset;
      meter_q.release_fraction  <= ReleaseReset;
      meter_q.live_mode         <= 1'b0;
      meter_q.silence_threshold <= ThresholdReset;
      pause_q                   <= COUNT_BITS'(PauseReset);
      min_q                     <= COUNT_BITS'(ChunkMinReset);
      max_q                     <= COUNT_BITS'(ChunkMaxReset);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ATTACK:    meter_q.attack_fraction   <= cfg_wdata_i[FracBits-1:0];
        CFG_RELEASE:   meter_q.release_fraction  <= cfg_wdata_i[FracBits-1:0];
        CFG_LIVE_MODE: meter_q.live_mode         <= cfg_wdata_i[0];
        CFG_THRESHOLD: meter_q.silence_threshold <= cfg_wdata_i[LevelBits-1:0];
        CFG_PAUSE:     pause_q                   <= cfg_wdata_i;
        CFG_CHUNK_MIN: min_q                     <= cfg_wdata_i;
        CFG_CHUNK_MAX: max_q                     <= cfg_wdata_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign meter_cfg_o     = meter_q;
  assign pause_samples_o = pause_q;
  assign chunk_min_o     = min_q;
  assign chunk_max_o     = max_q;
endmodule

/* design/lmsc_front.sv */
// Input register stage: takes a transfer and turns the sample into a Q0.15 magnitude.
module lmsc_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  lmsc_in_if.sink         in_i,
  output logic            item_valid_o,
  output lmsc_pkg::item_t item_o,
  input  logic            item_ready_i
);
  import lmsc_pkg::*;

  localparam int WideBits = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int ShiftR   = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;
  localparam int ShiftL   = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;

  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] abs_val;
  logic [WideBits-1:0]    abs_wide;
  logic [15:0]            scaled;
  item_t                  item_d;
  item_t                  item_q;
  logic                   valid_q;

  always_comb begin
    raw      = in_i.sample;
    // The most negative code maps to 2^(SAMPLE_BITS-1), which still fits unsigned.
    abs_val  = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    abs_wide = WideBits'(abs_val);
    scaled   = 16'((abs_wide >> ShiftR) << ShiftL);
    item_d.opcode     = opcode_e'(in_i.opcode);
    item_d.mag        = scaled[15] ? LevelMax : scaled[LevelBits-1:0];
    item_d.buffer_end = in_i.buffer_end;
  end

  assign in_i.ready = !valid_q || item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;
endmodule

/* design/lmsc_core.sv */
// Meter and chunk state update with the result register.
module lmsc_core #(
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lmsc_pkg::meter_cfg_t  meter_cfg_i,
  input  logic [COUNT_BITS-1:0] pause_samples_i,
  input  logic [COUNT_BITS-1:0] chunk_min_i,
  input  logic [COUNT_BITS-1:0] chunk_max_i,
  input  logic                  item_valid_i,
  input  lmsc_pkg::item_t       item_i,
  output logic                  item_ready_o,
  lmsc_out_if.source            out_o
);
  import lmsc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic                  rec_q, rec_d;
  logic [LevelBits-1:0]  peak_q, peak_d;
  logic [LevelBits-1:0]  level_q, level_d;
  logic [COUNT_BITS-1:0] bcount_q, bcount_d;
  logic [COUNT_BITS-1:0] silence_q, silence_d;
  logic [COUNT_BITS-1:0] ccount_q, ccount_d;

  logic                  out_valid_q;
  logic [LevelBits-1:0]  res_level_q, res_level_d;
  logic                  res_cut_q, res_cut_d;
  logic                  res_fin_q, res_fin_d;
  logic [COUNT_BITS-1:0] res_len_q, res_len_d;
  logic                  res_fire;

  logic                  take;
  logic [LevelBits-1:0]  peak_max;
  logic [COUNT_BITS-1:0] bcount_inc;
  logic [COUNT_BITS-1:0] ccount_inc;
  logic                  going_down;
  logic [LevelBits-1:0]  diff;
  logic [FracBits-1:0]   frac;
  logic [30:0]           prod;
  logic [15:0]           step_dn;
  logic [15:0]           level_up;
  logic [LevelBits-1:0]  level_new;
  logic [COUNT_BITS:0]   silence_sum;
  logic [COUNT_BITS-1:0] silence_sat;
  logic [COUNT_BITS-1:0] silence_new;
  logic                  at_pause;
  logic                  at_cap;

  assign item_ready_o = !out_valid_q || out_o.ready;
  assign take         = item_valid_i && item_ready_o;

  // Level smoothing, peak and counter arithmetic for a sample; level and silence results apply at a buffer end.
  always_comb begin
    peak_max   = (item_i.mag > peak_q) ? item_i.mag : peak_q;
    bcount_inc = (bcount_q == CountMax) ? bcount_q : bcount_q + 1'b1;
    ccount_inc = (ccount_q == CountMax) ? ccount_q : ccount_q + 1'b1;

    going_down = level_q > peak_max;
    diff       = going_down ? level_q - peak_max : peak_max - level_q;
    frac       = (peak_max > level_q) ? meter_cfg_i.attack_fraction
                                      : meter_cfg_i.release_fraction;
    prod       = 31'(diff) * 31'(frac);
    // Falling step rounds toward minus infinity: ceil of the magnitude.
    step_dn    = 16'((32'(prod) + 32'd65535) >> 16);
    level_up   = 16'(level_q) + 16'(prod[30:16]);
    if (going_down) begin
      level_new = (16'(level_q) > step_dn) ? LevelBits'(16'(level_q) - step_dn) : '0;
    end else begin
      level_new = level_up[15] ? LevelMax : level_up[LevelBits-1:0];
    end

    silence_sum = {1'b0, silence_q} + {1'b0, bcount_inc};
    silence_sat = silence_sum[COUNT_BITS] ? CountMax : silence_sum[COUNT_BITS-1:0];
    silence_new = (peak_max < meter_cfg_i.silence_threshold) ? silence_sat : '0;
    at_pause    = (ccount_inc >= chunk_min_i) && (silence_new >= pause_samples_i);
    at_cap      = ccount_inc >= chunk_max_i;
  end

  always_comb begin
    rec_d       = rec_q;
    peak_d      = peak_q;
    level_d     = level_q;
    bcount_d    = bcount_q;
    silence_d   = silence_q;
    ccount_d    = ccount_q;
    res_fire    = 1'b0;
    res_level_d = level_q;
    res_cut_d   = 1'b0;
    res_fin_d   = 1'b0;
    res_len_d   = '0;

    if (take) begin
      unique case (item_i.opcode)
        OP_START: begin
          if (!rec_q) begin
            rec_d     = 1'b1;
            peak_d    = '0;
            level_d   = '0;
            bcount_d  = '0;
            silence_d = '0;
            ccount_d  = '0;
          end
        end
        OP_STOP: begin
          if (rec_q) begin
            rec_d       = 1'b0;
            peak_d      = '0;
            level_d     = '0;
            bcount_d    = '0;
            res_fire    = 1'b1;
            res_level_d = '0;
            if (meter_cfg_i.live_mode) begin
              res_cut_d = 1'b1;
              res_fin_d = 1'b1;
              res_len_d = ccount_q;
              ccount_d  = '0;
              silence_d = '0;
            end
          end
        end
        OP_SAMPLE: begin
          if (rec_q) begin
            ccount_d = ccount_inc;
            if (!item_i.buffer_end) begin
              peak_d   = peak_max;
              bcount_d = bcount_inc;
            end else begin
              peak_d      = '0;
              bcount_d    = '0;
              level_d     = level_new;
              res_fire    = 1'b1;
              res_level_d = level_new;
              if (meter_cfg_i.live_mode) begin
                silence_d = silence_new;
                if (at_pause || at_cap) begin
                  res_cut_d = 1'b1;
                  res_len_d = ccount_inc;
                  ccount_d  = '0;
                  silence_d = '0;
                end
              end
            end
          end
        end
        default: ;  // drop the unused opcode
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q       <= 1'b0;
      peak_q      <= '0;
      level_q     <= '0;
      bcount_q    <= '0;
      silence_q   <= '0;
      ccount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rec_q     <= rec_d;
      peak_q    <= peak_d;
      level_q   <= level_d;
      bcount_q  <= bcount_d;
      silence_q <= silence_d;
      ccount_q  <= ccount_d;
      if (item_ready_o) begin
        out_valid_q <= res_fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      res_level_q <= res_level_d;
      res_cut_q   <= res_cut_d;
      res_fin_q   <= res_fin_d;
      res_len_q   <= res_len_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.level        = res_level_q;
  assign out_o.cut          = res_cut_q;
  assign out_o.final_chunk  = res_fin_q;
  assign out_o.chunk_length = res_len_q;
endmodule

/* design/level_meter_silence_chunker.sv */
// Level meter with silence-based chunk cutting, top level.
//
// Takes one item per clock: a start, a stop or a signed sample with a buffer-end
// flag. An item is registered at its transfer with its magnitude already scaled to
// Q0.15. The state update runs between that input register and the result
// register, so a result is registered as the state update takes its item and is
// valid from the cycle after. Items stream at one per cycle while the result
// channel is ready. The rate is set by the single state update per item: peak,
// level smoothing (one 15x16 multiply), silence run and chunk counters all settle
// in that update. Results come only at a buffer end or a stop while recording;
// a stalled result holds in the output register while one more item waits in the
// input register. Configuration writes take effect on the next item and belong
// between items, with the block idle.
module level_meter_silence_chunker #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lmsc_in_if.sink                           in_i,
  lmsc_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [lmsc_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [COUNT_BITS-1:0]             cfg_wdata_i
);
  import lmsc_pkg::*;

  meter_cfg_t            meter_cfg;
  logic [COUNT_BITS-1:0] pause_samples;
  logic [COUNT_BITS-1:0] chunk_min;
  logic [COUNT_BITS-1:0] chunk_max;
  logic                  item_valid;
  logic                  item_ready;
  item_t                 item;

  lmsc_cfg_regs #(
    .COUNT_BITS(COUNT_BITS)
  ) u_cfg_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .meter_cfg_o     (meter_cfg),
    .pause_samples_o (pause_samples),
    .chunk_min_o     (chunk_min),
    .chunk_max_o     (chunk_max)
  );

  lmsc_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  lmsc_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .meter_cfg_i     (meter_cfg),
    .pause_samples_i (pause_samples),
    .chunk_min_i     (chunk_min),
    .chunk_max_i     (chunk_max),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .item_ready_o    (item_ready),
    .out_o           (out_o)
  );
endmodule

/* design/lmsc_checker.sv */
// Port-level checker for the level meter and silence chunker, with its bind.
`include "assert_macros.svh"

module lmsc_checker #(
  parameter int COUNT_BITS = 24
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [14:0]           level_i,
  input logic                  cut_i,
  input logic                  final_i,
  input logic [COUNT_BITS-1:0] len_i
);
  // A closing chunk is always a cut and always reports a zeroed level.
  `LMSC_ASSERT_IMP(a_final_is_cut, clk_i, rst_ni, out_valid_i && final_i, cut_i && level_i == 15'd0)
  // No cut, no length.
  `LMSC_ASSERT_IMP(a_len_zero_no_cut, clk_i, rst_ni, out_valid_i && !cut_i, len_i == '0)
  // A cut at a buffer end always covers at least that buffer's last sample.
  `LMSC_ASSERT_IMP(a_cut_nonempty, clk_i, rst_ni, out_valid_i && cut_i && !final_i, len_i != '0)
  // Hold a stalled result.
  `LMSC_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(level_i) && $stable(cut_i) && $stable(final_i) && $stable(len_i))
endmodule

bind level_meter_silence_chunker lmsc_checker #(
  .COUNT_BITS(COUNT_BITS)
) u_lmsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .level_i     (out_o.level),
  .cut_i       (out_o.cut),
  .final_i     (out_o.final_chunk),
  .len_i       (out_o.chunk_length)
);
